// ===== rtl/core/device_id_whitelist_check_unit_macros.svh =====
// Assertion macros for the device ID whitelist check unit.
// Included by the checker file; no other dependencies.
`ifndef DEVICE_ID_WHITELIST_CHECK_UNIT_MACROS_SVH
`define DEVICE_ID_WHITELIST_CHECK_UNIT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define DWL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked across reset.
`define DWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dwl_pkg.sv =====
// Shared types, codes and constants for the device ID whitelist check unit.
// No dependencies.
package dwl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int CLASS_W         = 8;
    localparam int ENTRY_W         = 2 * ID_W;
    localparam int VERDICT_W       = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [ID_W-1:0]    VENDOR_ALL_ONES  = 16'hFFFF;
    localparam logic [ID_W-1:0]    VENDOR_ZERO      = 16'h0000;
    localparam logic [CLASS_W-1:0] EXEMPT_FIRST_RST = 8'h03;
    localparam logic [CLASS_W-1:0] EXEMPT_SECOND_RST = 8'h06;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_CHECK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCKDOWN      = 2'd0,
        CFG_EXEMPT_FIRST  = 2'd1,
        CFG_EXEMPT_SECOND = 2'd2
    } t_cfg_idx;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_STORED   = 3'd0,
        VERDICT_FULL     = 3'd1,
        VERDICT_DISABLED = 3'd2,
        VERDICT_VACANT   = 3'd3,
        VERDICT_EXEMPT   = 3'd4,
        VERDICT_MATCH    = 3'd5,
        VERDICT_UNAUTH   = 3'd6
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               lockdown;
        logic [CLASS_W-1:0] exempt_first;
        logic [CLASS_W-1:0] exempt_second;
    } t_cfg;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctl;

endpackage

// ===== rtl/core/dwl_table.sv =====
// Whitelist table: one vendor/device pair per entry, one write and one read port.
// Depends on dwl_pkg.
module dwl_table #(
    parameter int TABLE_DEPTH = dwl_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  dwl_pkg::t_tbl_ctl            i_ctl,
    input  logic [IDX_W-1:0]             i_wr_addr,
    input  logic [dwl_pkg::ENTRY_W-1:0]  i_wr_data,
    input  logic [IDX_W-1:0]             i_rd_addr,
    output logic [dwl_pkg::ENTRY_W-1:0]  o_rd_data
);
    import dwl_pkg::*;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dwl_ctrl.sv =====
// Sequencer for the whitelist check: decodes a transaction, steps one comparator
// over the table entries and holds the verdict in the output register.
// Depends on dwl_pkg.
module dwl_ctrl #(
    parameter int TABLE_DEPTH = dwl_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [dwl_pkg::ID_W-1:0]       i_vendor_id,
    input  logic [dwl_pkg::ID_W-1:0]       i_device_id,
    input  logic [dwl_pkg::CLASS_W-1:0]    i_class_code,
    input  dwl_pkg::t_cfg                  i_cfg,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dwl_pkg::VERDICT_W-1:0]  o_verdict,
    output dwl_pkg::t_tbl_ctl              o_tbl,
    output logic [IDX_W-1:0]               o_wr_addr,
    output logic [dwl_pkg::ENTRY_W-1:0]    o_wr_data,
    output logic [IDX_W-1:0]               o_rd_addr,
    input  logic [dwl_pkg::ENTRY_W-1:0]    i_rd_data
);
    import dwl_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] ZERO_C  = '0;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_cmp_last, n_cmp_last;
    logic [ID_W-1:0]   r_vid, n_vid;
    logic [ID_W-1:0]   r_did, n_did;
    t_verdict          r_verdict, n_verdict;
    logic              r_out_valid, n_out_valid;
    t_verdict          r_out_verdict, n_out_verdict;

    logic accept;
    logic issue;
    logic hit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = (r_state == ST_SCAN) && (r_idx < r_count);
    // Single shared comparator: registered table word against the held pair.
    assign hit        = r_cmp_vld && (i_rd_data == {r_vid, r_did});

    assign o_wr_addr  = r_count[IDX_W-1:0];
    assign o_wr_data  = {i_vendor_id, i_device_id};
    assign o_rd_addr  = r_idx[IDX_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_cmp_vld     = r_cmp_vld;
        n_cmp_last    = r_cmp_last;
        n_vid         = r_vid;
        n_did         = r_did;
        n_verdict     = r_verdict;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        o_tbl.wr_en   = 1'b0;
        o_tbl.rd_en   = issue;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_vid     = i_vendor_id;
                    n_did     = i_device_id;
                    n_idx     = ZERO_C;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_DONE;
                    if (t_op'(i_operation) == OP_INSERT) begin
                        if (r_count < DEPTH_C) begin
                            o_tbl.wr_en = 1'b1;
                            n_count     = r_count + ONE_C;
                            n_verdict   = VERDICT_STORED;
                        end else begin
                            n_verdict   = VERDICT_FULL;
                        end
                    end else if (!i_cfg.lockdown) begin
                        n_verdict = VERDICT_DISABLED;
                    end else if (i_vendor_id == VENDOR_ALL_ONES ||
                                 i_vendor_id == VENDOR_ZERO) begin
                        n_verdict = VERDICT_VACANT;
                    end else if (i_class_code == i_cfg.exempt_first ||
                                 i_class_code == i_cfg.exempt_second) begin
                        n_verdict = VERDICT_EXEMPT;
                    end else if (r_count == ZERO_C) begin
                        n_verdict = VERDICT_UNAUTH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; the compare lands in the following cycle.
                if (issue) begin
                    n_idx = r_idx + ONE_C;
                end
                n_cmp_vld  = issue;
                n_cmp_last = issue && ((r_idx + ONE_C) == r_count);
                if (hit) begin
                    n_verdict = VERDICT_MATCH;
                    n_state   = ST_DONE;
                end else if (r_cmp_vld && r_cmp_last) begin
                    n_verdict = VERDICT_UNAUTH;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the verdict until the output register frees up.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= ZERO_C;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_cmp_last    <= n_cmp_last;
        r_vid         <= n_vid;
        r_did         <= n_did;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
    end

endmodule

// ===== rtl/core/device_id_whitelist_check_unit.sv =====
// Device ID whitelist check unit: inserts and checks vendor/device ID pairs.
// Inserts and early verdicts go from accept straight to the done state; a table
// search first steps one comparator over the stored entries, reading one table
// entry per cycle through the single read port.
// One transaction in flight: the next is taken in the cycle after the result loads.
// Synchronous active-low reset empties the table and restores register defaults.
module device_id_whitelist_check_unit #(
    parameter int TABLE_DEPTH = dwl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dwl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dwl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [dwl_pkg::ID_W-1:0]          i_vendor_id,
    input  logic [dwl_pkg::ID_W-1:0]          i_device_id,
    input  logic [dwl_pkg::CLASS_W-1:0]       i_class_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dwl_pkg::VERDICT_W-1:0]     o_verdict
);
    import dwl_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_cfg               r_cfg, n_cfg;
    t_tbl_ctl           tbl_ctl;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOCKDOWN:      n_cfg.lockdown      = i_cfg_data[0];
                CFG_EXEMPT_FIRST:  n_cfg.exempt_first  = i_cfg_data[CLASS_W-1:0];
                CFG_EXEMPT_SECOND: n_cfg.exempt_second = i_cfg_data[CLASS_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockdown      <= 1'b1;
            r_cfg.exempt_first  <= EXEMPT_FIRST_RST;
            r_cfg.exempt_second <= EXEMPT_SECOND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dwl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_vendor_id  (i_vendor_id),
        .i_device_id  (i_device_id),
        .i_class_code (i_class_code),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_tbl        (tbl_ctl),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    dwl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== rtl/core/dwl_checker.sv =====
// Port-level checks for the device ID whitelist check unit, bound to the top level.
// Depends on device_id_whitelist_check_unit_macros.svh and dwl_pkg.
`include "device_id_whitelist_check_unit_macros.svh"

module dwl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [dwl_pkg::VERDICT_W-1:0]  o_verdict
);

    // A pending result transaction holds its verdict until taken.
    `DWL_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_verdict)), "result dropped or changed while stalled")

    // Only one transaction is worked on at a time.
    `DWL_ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken while a transaction is in flight")

    // A new result appears only after the block was busy with a transaction.
    `DWL_ASSERT_CLK(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready), "result without a transaction")

    // Reset empties the output register.
    `DWL_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind device_id_whitelist_check_unit dwl_checker u_dwl_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for device_id_whitelist_check_unit: directed verdict cases,
// a table fill, register sweeps, back-pressure and random traffic.
// Depends on dwl_pkg and the unit's RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dwl_pkg::*;

    localparam int DEPTH           = TABLE_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 32;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation = 1'b0;
    logic [ID_W-1:0]       i_vendor_id = '0;
    logic [ID_W-1:0]       i_device_id = '0;
    logic [CLASS_W-1:0]    i_class_code = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VERDICT_W-1:0]  o_verdict;

    always #2 i_clk = ~i_clk;

    device_id_whitelist_check_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_vendor_id  (i_vendor_id),
        .i_device_id  (i_device_id),
        .i_class_code (i_class_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict)
    );

    // Whitelist mirror and register copy
    logic [ID_W-1:0] wl_vendor [DEPTH];
    logic [ID_W-1:0] wl_device [DEPTH];
    int unsigned     wl_count;
    t_cfg            wl_cfg;

    t_verdict    pending_verdicts [$];
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned cfg_writes;
    int unsigned verdict_hits [0:6];
    int unsigned idle_cycles;
    bit          src_gaps_on;
    bit          sink_stalls_on;
    bit          sink_hold_req;

    function automatic void reset_whitelist();
        wl_count             = 0;
        wl_cfg.lockdown      = 1'b1;
        wl_cfg.exempt_first  = EXEMPT_FIRST_RST;
        wl_cfg.exempt_second = EXEMPT_SECOND_RST;
    endfunction

    function automatic t_verdict whitelist_verdict(t_op op, logic [ID_W-1:0] vid,
                                                   logic [ID_W-1:0] did,
                                                   logic [CLASS_W-1:0] cls);
        t_verdict v;
        if (op == OP_INSERT) begin
            if (wl_count >= DEPTH) begin
                v = VERDICT_FULL;
            end else begin
                wl_vendor[wl_count] = vid;
                wl_device[wl_count] = did;
                wl_count++;
                v = VERDICT_STORED;
            end
        end else if (!wl_cfg.lockdown) begin
            v = VERDICT_DISABLED;
        end else if (vid == VENDOR_ALL_ONES || vid == VENDOR_ZERO) begin
            v = VERDICT_VACANT;
        end else if (cls == wl_cfg.exempt_first || cls == wl_cfg.exempt_second) begin
            v = VERDICT_EXEMPT;
        end else begin
            v = VERDICT_UNAUTH;
            for (int k = 0; k < wl_count; k++) begin
                if (wl_vendor[k] == vid && wl_device[k] == did) v = VERDICT_MATCH;
            end
        end
        return v;
    endfunction

    function automatic void apply_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LOCKDOWN:      wl_cfg.lockdown      = data[0];
            CFG_EXEMPT_FIRST:  wl_cfg.exempt_first  = data;
            CFG_EXEMPT_SECOND: wl_cfg.exempt_second = data;
            default: ;
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_cfg(idx, data);
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Valid stays high after a transaction unless a gap is drawn; callers that
    // do not send next must drop it in the same step (wait_idle does).
    task automatic send_item(t_op op, logic [ID_W-1:0] vid, logic [ID_W-1:0] did,
                             logic [CLASS_W-1:0] cls);
        int gap;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_vendor_id  <= vid;
        i_device_id  <= did;
        i_class_code <= cls;
        do @(posedge i_clk); while (!o_in_ready);
        pending_verdicts.push_back(whitelist_verdict(op, vid, did, cls));
        items_sent++;
        if (src_gaps_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(bit lock, logic [CLASS_W-1:0] first,
                               logic [CLASS_W-1:0] second);
        wait_idle();
        // Upper data bits are don't-care for the lockdown bit; toggle them anyway.
        write_reg(CFG_LOCKDOWN, {7'($urandom_range(0, 127)), lock});
        write_reg(CFG_EXEMPT_FIRST, first);
        write_reg(CFG_EXEMPT_SECOND, second);
    endtask

    task automatic run_random_items(int count);
        t_op                op;
        logic [ID_W-1:0]    vid;
        logic [ID_W-1:0]    did;
        logic [CLASS_W-1:0] cls;
        int                 pick;
        int                 sel;
        int                 slot;
        for (int n = 0; n < count; n++) begin
            op  = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_CHECK;
            vid = 16'($urandom);
            did = 16'($urandom);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                vid = $urandom_range(0, 1) ? VENDOR_ALL_ONES : VENDOR_ZERO;
            end else if (sel <= 6 && wl_count > 0) begin
                slot = $urandom_range(0, wl_count - 1);
                vid  = wl_vendor[slot];
                did  = wl_device[slot];
                // near miss: flip a single ID bit
                if (sel == 6) {vid, did} = {vid, did} ^ (32'd1 << $urandom_range(0, 31));
            end
            pick = $urandom_range(0, 7);
            if (pick == 0)      cls = wl_cfg.exempt_first;
            else if (pick == 1) cls = wl_cfg.exempt_second;
            else                cls = 8'($urandom);
            send_item(op, vid, did, cls);
        end
    endtask

    task automatic test_verdict_order();
        send_item(OP_CHECK, 16'hFFFF, 16'h1234, 8'h03);
        send_item(OP_CHECK, 16'h0000, 16'hFFFF, 8'h06);
        send_item(OP_CHECK, 16'h8001, 16'h0001, 8'h03);
        send_item(OP_CHECK, 16'h7FFE, 16'hFFFF, 8'h06);
        send_item(OP_CHECK, 16'h1234, 16'h5678, 8'h00);
        send_item(OP_INSERT, 16'h1234, 16'h5678, 8'hFF);
        send_item(OP_INSERT, 16'h0000, 16'h0000, 8'h00);
        send_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 8'h00);
        send_item(OP_INSERT, 16'h1234, 16'h5678, 8'h03);
        send_item(OP_CHECK, 16'h1234, 16'h5678, 8'hFF);
        send_item(OP_CHECK, 16'h1234, 16'h5679, 8'h02);
        wait_idle();
        write_reg(CFG_LOCKDOWN, 8'hFE);
        send_item(OP_CHECK, 16'h0000, 16'h0000, 8'h03);
        send_item(OP_CHECK, 16'h1234, 16'h5678, 8'h03);
        // inserts still land while the check is off
        send_item(OP_INSERT, 16'hA5A5, 16'h5A5A, 8'hFF);
        wait_idle();
        write_reg(CFG_LOCKDOWN, 8'h01);
    endtask

    task automatic test_table_fill();
        logic [ID_W-1:0] vid;
        logic [ID_W-1:0] did;
        while (wl_count < DEPTH) begin
            vid = 16'($urandom_range(1, 16'hFFFE));
            did = 16'($urandom);
            send_item(OP_INSERT, vid, did, 8'($urandom));
        end
        send_item(OP_INSERT, 16'hBEEF, 16'hCAFE, 8'h00);
        send_item(OP_CHECK, wl_vendor[DEPTH-1], wl_device[DEPTH-1], 8'h00);
        send_item(OP_CHECK, wl_vendor[0], wl_device[0], 8'h80);
    endtask

    task automatic test_register_sweep();
        load_config(1'b1, 8'h00, 8'hFF);
        run_random_items(40);
        load_config(1'b1, 8'hFF, 8'h00);
        run_random_items(40);
        load_config(1'b1, 8'h80, 8'h80);
        run_random_items(40);
        load_config(1'b0, EXEMPT_FIRST_RST, EXEMPT_SECOND_RST);
        run_random_items(40);
        load_config(1'b1, EXEMPT_FIRST_RST, EXEMPT_SECOND_RST);
        run_random_items(40);
    endtask

    task automatic test_receiver_holdoff();
        wait_idle();
        src_gaps_on   = 1'b0;
        sink_hold_req = 1'b1;
        run_random_items(24);
        // pause until the whole backlog has drained
        wait_idle();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_items(120);
    endtask

    task automatic test_streaming();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        run_random_items(60);
    endtask

    initial begin : result_sink
        int n;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict expected_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                error_count++;
                $error("verdict: expected none, actual %0d", o_verdict);
            end else begin
                expected_v = pending_verdicts.pop_front();
                verdict_hits[expected_v]++;
                if (o_verdict !== expected_v) begin
                    error_count++;
                    $error("verdict: expected %0d (%s), actual %0d",
                           expected_v, expected_v.name(), o_verdict);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("device_id_whitelist_check_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        sink_hold_req  = 1'b0;
        reset_whitelist();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_verdict_order();
        test_table_fill();
        test_register_sweep();
        test_receiver_holdoff();
        test_random_traffic();
        test_streaming();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions, %0d results, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("verdicts stored %0d full %0d disabled %0d vacant %0d exempt %0d match %0d unauth %0d",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
                 verdict_hits[4], verdict_hits[5], verdict_hits[6]);
        if (error_count == 0) begin
            $display("device_id_whitelist_check_unit regression: pass");
        end else begin
            $display("device_id_whitelist_check_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dwl_pkg.sv
rtl/core/dwl_table.sv
rtl/core/dwl_ctrl.sv
rtl/core/device_id_whitelist_check_unit.sv
rtl/core/dwl_checker.sv
bench/testbench.sv
